// File: sv/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB channel writer.
`default_nettype none

package hsvrgb_pkg;

    // Upper bound on the channel count, whatever num_outputs says
    localparam int MAX_CHANNELS = 1024;

    // Hue geometry: one sextant spans 60 degrees, a full turn 360
    localparam int HUE_TURN     = 360;
    localparam int SEXT_SPAN    = 60;

    // floor(x / 60) == (x * RECIP_60) >> RECIP_SHIFT for every x below 23831
    localparam int RECIP_60     = 17477;
    localparam int RECIP_SHIFT  = 20;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MAX_BRIGHTNESS = 2'd0,
        CFG_PIN_GROUPING   = 2'd1,
        CFG_NUM_OUTPUTS    = 2'd2
    } cfg_index_t;

    // Hue sextants, named by which primary is ramping
    typedef enum logic [2:0] {
        SEXT_GREEN_UP   = 3'd0,
        SEXT_RED_DOWN   = 3'd1,
        SEXT_BLUE_UP    = 3'd2,
        SEXT_GREEN_DOWN = 3'd3,
        SEXT_RED_UP     = 3'd4,
        SEXT_BLUE_DOWN  = 3'd5
    } sextant_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic [7:0]  max_brightness;
        logic [4:0]  pin_grouping;
        logic [10:0] num_outputs;
    } cfg_t;

    // Per-stage load enables
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// File: sv/hsvrgb_index_pipe.sv
// Channel index path: pipelined led / grouping divide, base index and range check.
`default_nettype none

module hsvrgb_index_pipe (
    input  logic                  clk,
    input  hsvrgb_pkg::pipe_ctl_t ctl,
    input  hsvrgb_pkg::cfg_t      cfg,
    input  logic [7:0]            led_number,
    input  logic [7:0]            channel_offset,
    output logic                  ok_s3,
    output logic                  ok,
    output logic [9:0]            red_index,
    output logic [9:0]            green_index,
    output logic [9:0]            blue_index
);
    import hsvrgb_pkg::*;

    // One restoring divide step: {quotient bit, new remainder}
    function automatic logic [5:0] div_step(input logic [4:0] rem, input logic din,
                                            input logic [4:0] div);
        logic [5:0] trial;
        trial = {rem, din};
        if (trial >= {1'b0, div})
        begin
            div_step = {1'b1, 5'(trial - {1'b0, div})};
        end
        else
        begin
            div_step = {1'b0, trial[4:0]};
        end
    endfunction

    // Stage 1 signals
    logic [4:0]  rem_a [0:4];
    logic [3:0]  q_hi;
    logic [7:0]  led_s1_reg;
    logic [7:0]  off_s1_reg;
    logic [4:0]  rem_s1_reg;
    logic [3:0]  qhi_s1_reg;

    // Stage 2 signals
    logic [4:0]  rem_b [0:4];
    logic [3:0]  q_lo;
    logic [7:0]  led_s2_reg;
    logic [7:0]  off_s2_reg;
    logic [7:0]  quo_s2_reg;

    // Stage 3 signals
    logic [12:0] grp_prod;
    logic [14:0] base;
    logic [14:0] mid;
    logic [14:0] last;
    logic [10:0] limit;
    logic        ok_next;
    logic [9:0]  idx0_s3_reg;
    logic [9:0]  idx1_s3_reg;
    logic [9:0]  idx2_s3_reg;
    logic        ok_s3_reg;

    // Stage 4 registers
    logic [9:0]  idx0_s4_reg;
    logic [9:0]  idx1_s4_reg;
    logic [9:0]  idx2_s4_reg;
    logic        ok_s4_reg;

    // Upper four quotient bits
    always_comb
    begin
        rem_a[0] = '0;
        for (int i = 0; i < 4; i++)
        begin
            {q_hi[3 - i], rem_a[i + 1]} = div_step(rem_a[i], led_number[7 - i],
                                                   cfg.pin_grouping);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            led_s1_reg <= led_number;
            off_s1_reg <= channel_offset;
            rem_s1_reg <= rem_a[4];
            qhi_s1_reg <= q_hi;
        end
    end

    // Lower four quotient bits
    always_comb
    begin
        rem_b[0] = rem_s1_reg;
        for (int i = 0; i < 4; i++)
        begin
            {q_lo[3 - i], rem_b[i + 1]} = div_step(rem_b[i], led_s1_reg[3 - i],
                                                   cfg.pin_grouping);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            led_s2_reg <= led_s1_reg;
            off_s2_reg <= off_s1_reg;
            quo_s2_reg <= {qhi_s1_reg, q_lo};
        end
    end

    // Base index, stride and range check; zero the indices when out of range
    always_comb
    begin
        grp_prod = 13'(cfg.pin_grouping) * 13'(quo_s2_reg);
        base     = 15'(led_s2_reg) + {1'b0, grp_prod, 1'b0} + 15'(off_s2_reg);
        mid      = base + 15'(cfg.pin_grouping);
        last     = mid + 15'(cfg.pin_grouping);
        limit    = (cfg.num_outputs < 11'(MAX_CHANNELS)) ? cfg.num_outputs
                                                         : 11'(MAX_CHANNELS);
        ok_next  = (cfg.pin_grouping != '0) && (last < 15'(limit));
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            ok_s3_reg   <= ok_next;
            idx0_s3_reg <= ok_next ? base[9:0] : '0;
            idx1_s3_reg <= ok_next ? mid[9:0]  : '0;
            idx2_s3_reg <= ok_next ? last[9:0] : '0;
        end
    end

    // Hold indices in line with the level path
    always_ff @(posedge clk)
    begin
        if (ctl.ld4)
        begin
            ok_s4_reg   <= ok_s3_reg;
            idx0_s4_reg <= idx0_s3_reg;
            idx1_s4_reg <= idx1_s3_reg;
            idx2_s4_reg <= idx2_s3_reg;
        end
    end

    assign ok_s3       = ok_s3_reg;
    assign ok          = ok_s4_reg;
    assign red_index   = idx0_s4_reg;
    assign green_index = idx1_s4_reg;
    assign blue_index  = idx2_s4_reg;

endmodule

`default_nettype wire

// File: sv/hsvrgb_color_pipe.sv
// Color path: sextant split, ramp products, divide by 60 and brightness scaling.
`default_nettype none

module hsvrgb_color_pipe (
    input  logic                  clk,
    input  hsvrgb_pkg::pipe_ctl_t ctl,
    input  hsvrgb_pkg::cfg_t      cfg,
    input  logic [8:0]            hue,
    input  logic [7:0]            saturation,
    input  logic [7:0]            brightness_value,
    input  logic                  ok_s3,
    output logic [7:0]            red_level,
    output logic [7:0]            green_level,
    output logic [7:0]            blue_level
);
    import hsvrgb_pkg::*;

    // Stage 1 signals
    logic [8:0]  hue_w;
    sextant_t    sext;
    logic [8:0]  sext_start;
    logic [15:0] bot_prod;
    logic [7:0]  val_s1_reg;
    logic [15:0] bprod_s1_reg;
    logic [5:0]  frac_s1_reg;
    sextant_t    sext_s1_reg;

    // Stage 2 signals
    logic [7:0]  bottom;
    logic [7:0]  span;
    logic [5:0]  frac_inv;
    logic [7:0]  val_s2_reg;
    logic [7:0]  bot_s2_reg;
    logic [13:0] rise_s2_reg;
    logic [13:0] fall_s2_reg;
    sextant_t    sext_s2_reg;

    // Stage 3 signals
    logic [28:0] rise_m;
    logic [28:0] fall_m;
    logic [7:0]  rising;
    logic [7:0]  falling;
    logic [7:0]  r_c;
    logic [7:0]  g_c;
    logic [7:0]  b_c;
    logic [7:0]  r_s3_reg;
    logic [7:0]  g_s3_reg;
    logic [7:0]  b_s3_reg;

    // Stage 4 signals
    logic [15:0] r_scl;
    logic [15:0] g_scl;
    logic [15:0] b_scl;
    logic [7:0]  r_s4_reg;
    logic [7:0]  g_s4_reg;
    logic [7:0]  b_s4_reg;

    // Wrap hue once, find sextant and position inside it, form bottom product
    always_comb
    begin
        hue_w = (hue >= 9'(HUE_TURN)) ? 9'(hue - 9'(HUE_TURN)) : hue;
        if (hue_w >= 9'(5 * SEXT_SPAN))
        begin
            sext = SEXT_BLUE_DOWN;
            sext_start = 9'(5 * SEXT_SPAN);
        end
        else if (hue_w >= 9'(4 * SEXT_SPAN))
        begin
            sext = SEXT_RED_UP;
            sext_start = 9'(4 * SEXT_SPAN);
        end
        else if (hue_w >= 9'(3 * SEXT_SPAN))
        begin
            sext = SEXT_GREEN_DOWN;
            sext_start = 9'(3 * SEXT_SPAN);
        end
        else if (hue_w >= 9'(2 * SEXT_SPAN))
        begin
            sext = SEXT_BLUE_UP;
            sext_start = 9'(2 * SEXT_SPAN);
        end
        else if (hue_w >= 9'(SEXT_SPAN))
        begin
            sext = SEXT_RED_DOWN;
            sext_start = 9'(SEXT_SPAN);
        end
        else
        begin
            sext = SEXT_GREEN_UP;
            sext_start = '0;
        end
        bot_prod = 16'(8'd255 - saturation) * 16'(brightness_value);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld1)
        begin
            val_s1_reg   <= brightness_value;
            bprod_s1_reg <= bot_prod;
            frac_s1_reg  <= 6'(hue_w - sext_start);
            sext_s1_reg  <= sext;
        end
    end

    // Ramp numerators
    always_comb
    begin
        bottom   = bprod_s1_reg[15:8];
        span     = val_s1_reg - bottom;
        frac_inv = 6'(SEXT_SPAN) - frac_s1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld2)
        begin
            val_s2_reg  <= val_s1_reg;
            bot_s2_reg  <= bottom;
            rise_s2_reg <= 14'(span) * 14'(frac_s1_reg);
            fall_s2_reg <= 14'(span) * 14'(frac_inv);
            sext_s2_reg <= sext_s1_reg;
        end
    end

    // Divide ramps by 60 and route to the primaries
    always_comb
    begin
        rise_m  = 29'(rise_s2_reg) * 29'(RECIP_60);
        fall_m  = 29'(fall_s2_reg) * 29'(RECIP_60);
        rising  = 8'(rise_m >> RECIP_SHIFT) + bot_s2_reg;
        falling = 8'(fall_m >> RECIP_SHIFT) + bot_s2_reg;
        case (sext_s2_reg)
            SEXT_GREEN_UP:
            begin
                r_c = val_s2_reg; g_c = rising;     b_c = bot_s2_reg;
            end
            SEXT_RED_DOWN:
            begin
                r_c = falling;    g_c = val_s2_reg; b_c = bot_s2_reg;
            end
            SEXT_BLUE_UP:
            begin
                r_c = bot_s2_reg; g_c = val_s2_reg; b_c = rising;
            end
            SEXT_GREEN_DOWN:
            begin
                r_c = bot_s2_reg; g_c = falling;    b_c = val_s2_reg;
            end
            SEXT_RED_UP:
            begin
                r_c = rising;     g_c = bot_s2_reg; b_c = val_s2_reg;
            end
            default:
            begin
                r_c = val_s2_reg; g_c = bot_s2_reg; b_c = falling;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld3)
        begin
            r_s3_reg <= r_c;
            g_s3_reg <= g_c;
            b_s3_reg <= b_c;
        end
    end

    // Scale by full-scale brightness, drop to zero when out of range
    always_comb
    begin
        r_scl = 16'(r_s3_reg) * 16'(cfg.max_brightness);
        g_scl = 16'(g_s3_reg) * 16'(cfg.max_brightness);
        b_scl = 16'(b_s3_reg) * 16'(cfg.max_brightness);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.ld4)
        begin
            r_s4_reg <= ok_s3 ? r_scl[15:8] : '0;
            g_s4_reg <= ok_s3 ? g_scl[15:8] : '0;
            b_s4_reg <= ok_s3 ? b_scl[15:8] : '0;
        end
    end

    assign red_level   = r_s4_reg;
    assign green_level = g_s4_reg;
    assign blue_level  = b_s4_reg;

endmodule

`default_nettype wire

// File: sv/hsv_to_rgb_channel_writer_top.sv
// Top level of the HSV to RGB channel writer: config registers, pipeline control, ports.
//
// Channel   | Signals                          | Contents (low bit first)
// ----------+----------------------------------+---------------------------------------
// input     | s_tvalid s_tready s_tdata[47:0]  | led_number, hue, saturation,
//           |                                  | brightness_value, channel_offset, pad
// output    | m_tvalid m_tready m_tdata[55:0]  | red/green/blue_index, red/green/blue_level
//           | m_tuser[0]                       | ok
// config    | cfg_wr_en cfg_addr cfg_wdata     | max_brightness, pin_grouping, num_outputs
//
// One transaction per cycle in and out while m_tready is high, through the four
// register stages (divide upper half, divide lower half / ramp products, divide
// by 60 / base index, brightness multiply). A stall on m_tready backs up through
// the stage valids and frees s_tready again as soon as a bubble exists.
// Reset clears the stage valids and loads the register defaults.
`default_nettype none

module hsv_to_rgb_channel_writer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // led_number[7:0], hue[16:8], saturation[24:17],
                                    // brightness_value[32:25], channel_offset[40:33]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // red_index[9:0], green_index[19:10],
                                    // blue_index[29:20], red_level[37:30],
                                    // green_level[45:38], blue_level[53:46]
    output logic [0:0]  m_tuser,    // ok[0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [10:0] cfg_wdata
);
    import hsvrgb_pkg::*;

    cfg_t       cfg_reg;
    logic [3:0] vld_reg;
    logic [3:0] vld_next;
    logic [3:0] rdy;
    pipe_ctl_t  ctl;

    logic       ok;
    logic       ok_s3;
    logic [9:0] red_index;
    logic [9:0] green_index;
    logic [9:0] blue_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_brightness <= '0;
            cfg_reg.pin_grouping   <= 5'd1;
            cfg_reg.num_outputs    <= 11'(MAX_CHANNELS);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_addr))
                CFG_MAX_BRIGHTNESS: cfg_reg.max_brightness <= cfg_wdata[7:0];
                CFG_PIN_GROUPING:   cfg_reg.pin_grouping   <= cfg_wdata[4:0];
                CFG_NUM_OUTPUTS:    cfg_reg.num_outputs    <= cfg_wdata;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Stage can load when empty or when its contents move on
    always_comb
    begin
        rdy[3]   = !vld_reg[3] || m_tready;
        rdy[2]   = !vld_reg[2] || rdy[3];
        rdy[1]   = !vld_reg[1] || rdy[2];
        rdy[0]   = !vld_reg[0] || rdy[1];
        ctl.ld1  = rdy[0];
        ctl.ld2  = rdy[1];
        ctl.ld3  = rdy[2];
        ctl.ld4  = rdy[3];
        vld_next[0] = rdy[0] ? s_tvalid   : vld_reg[0];
        vld_next[1] = rdy[1] ? vld_reg[0] : vld_reg[1];
        vld_next[2] = rdy[2] ? vld_reg[1] : vld_reg[2];
        vld_next[3] = rdy[3] ? vld_reg[2] : vld_reg[3];
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    hsvrgb_index_pipe u_index (
        .clk            (clk),
        .ctl            (ctl),
        .cfg            (cfg_reg),
        .led_number     (s_tdata[7:0]),
        .channel_offset (s_tdata[40:33]),
        .ok_s3          (ok_s3),
        .ok             (ok),
        .red_index      (red_index),
        .green_index    (green_index),
        .blue_index     (blue_index)
    );

    hsvrgb_color_pipe u_color (
        .clk              (clk),
        .ctl              (ctl),
        .cfg              (cfg_reg),
        .hue              (s_tdata[16:8]),
        .saturation       (s_tdata[24:17]),
        .brightness_value (s_tdata[32:25]),
        .ok_s3            (ok_s3),
        .red_level        (red_level),
        .green_level      (green_level),
        .blue_level       (blue_level)
    );

    assign s_tready = rdy[0];
    assign m_tvalid = vld_reg[3];
    assign m_tuser  = ok;
    assign m_tdata  = {2'b00, blue_level, green_level, red_level,
                       blue_index, green_index, red_index};

endmodule

`default_nettype wire

// File: sv/hsvrgb_checker.sv
// Port-level checker for the HSV to RGB channel writer, bound to the top level.
`default_nettype none

module hsvrgb_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [0:0]  m_tuser
);

    // A stalled result holds its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // An out-of-range result carries only zeros
    a_not_ok_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("out-of-range result not zeroed");

    // In-range indices step by the same stride
    a_stride: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |->
            10'(m_tdata[19:10] - m_tdata[9:0]) == 10'(m_tdata[29:20] - m_tdata[19:10]))
        else $error("channel indices not evenly spaced");

    // A free output side never holds back the input side
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled while output is ready");

endmodule

bind hsv_to_rgb_channel_writer_top hsvrgb_checker u_hsvrgb_checker (.*);

`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the HSV to RGB channel writer: streamed colors, predicted channels.
`timescale 1ns / 1ps

module testbench;
    import hsvrgb_pkg::*;

    localparam int DRAIN_CYCLES = 8;     // four pipeline stages plus margin
    localparam int IDLE_LIMIT   = 5000;  // cycles with no transaction before giving up
    localparam int RANDOM_PHASES = 14;
    localparam int PHASE_ITEMS   = 73;

    // One color command as carried on the input stream
    typedef struct {
        logic [7:0] led;
        logic [8:0] hue;
        logic [7:0] sat;
        logic [7:0] val;
        logic [7:0] offset;
    } color_cmd_t;

    // One channel write as carried on the output stream
    typedef struct {
        logic       ok;
        logic [9:0] red_idx;
        logic [9:0] green_idx;
        logic [9:0] blue_idx;
        logic [7:0] red_lvl;
        logic [7:0] green_lvl;
        logic [7:0] blue_lvl;
    } channel_set_t;

    // Receiver stall styles
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // led_number, hue, saturation, brightness_value,
                                  // channel_offset, pad (lowest bit up)
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // red/green/blue_index, red/green/blue_level, pad
    logic [0:0]  m_tuser;         // ok
    logic        cfg_wr_en = 1'b0;
    cfg_index_t  cfg_addr = CFG_MAX_BRIGHTNESS;
    logic [10:0] cfg_wdata = '0;

    // Register copies used for prediction
    int unsigned bright_cfg  = 0;
    int unsigned group_cfg   = 1;
    int unsigned outputs_cfg = 1024;

    color_cmd_t   pending_cmds[$];
    channel_set_t expected_channels[$];
    color_cmd_t   cur_cmd;
    int unsigned  mismatch_count = 0;

    // Sender pacing
    int unsigned burst_left = 1;
    int unsigned gap_left = 0;
    logic        send_next;

    // Receiver pacing
    rx_style_t   rx_style = RX_OPEN;
    int unsigned rx_left = 0;
    logic [2:0]  rx_phase = '0;

    int unsigned idle_cycles = 0;

    hsv_to_rgb_channel_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock and reset
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Work out the channel write for one color under the current registers
    function automatic channel_set_t predict_channels(color_cmd_t c);
        channel_set_t r;
        int unsigned  limit, g, base, h, bottom, top, frac, rising, falling;
        int unsigned  red, green, blue;
        sextant_t     sx;
        r = '{default: '0};
        limit = (outputs_cfg < MAX_CHANNELS) ? outputs_cfg : MAX_CHANNELS;
        g = group_cfg;
        if (g == 0)
            return r;
        base = c.led + 2 * g * (c.led / g) + c.offset;
        if (base + 2 * g >= limit)
            return r;

        // Fold hue past a full turn back once
        h = c.hue;
        if (h >= HUE_TURN)
            h = h - HUE_TURN;
        bottom  = ((255 - c.sat) * c.val) >> 8;
        top     = c.val;
        frac    = h % SEXT_SPAN;
        rising  = ((top - bottom) * frac) / SEXT_SPAN + bottom;
        falling = ((top - bottom) * (SEXT_SPAN - frac)) / SEXT_SPAN + bottom;
        sx = sextant_t'(h / SEXT_SPAN);
        case (sx)
            SEXT_GREEN_UP:   begin red = top;     green = rising;  blue = bottom;  end
            SEXT_RED_DOWN:   begin red = falling; green = top;     blue = bottom;  end
            SEXT_BLUE_UP:    begin red = bottom;  green = top;     blue = rising;  end
            SEXT_GREEN_DOWN: begin red = bottom;  green = falling; blue = top;     end
            SEXT_RED_UP:     begin red = rising;  green = bottom;  blue = top;     end
            default:         begin red = top;     green = bottom;  blue = falling; end
        endcase

        r.ok        = 1'b1;
        r.red_idx   = 10'(base);
        r.green_idx = 10'(base + g);
        r.blue_idx  = 10'(base + 2 * g);
        r.red_lvl   = 8'(((red & 8'hFF) * bright_cfg) >> 8);
        r.green_lvl = 8'(((green & 8'hFF) * bright_cfg) >> 8);
        r.blue_lvl  = 8'(((blue & 8'hFF) * bright_cfg) >> 8);
        return r;
    endfunction

    // Random color, mostly landing on valid channels for the current grouping
    function automatic color_cmd_t random_color_cmd();
        color_cmd_t  c;
        int unsigned g, span, led_top, off_top;
        g = (group_cfg == 0) ? 1 : group_cfg;
        span = (outputs_cfg < MAX_CHANNELS) ? outputs_cfg : MAX_CHANNELS;
        c.hue = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(360, 511))
                                            : 9'($urandom_range(0, 359));
        c.sat = ($urandom_range(0, 7) == 0) ? 8'(255 * $urandom_range(0, 1))
                                            : 8'($urandom_range(0, 255));
        c.val = ($urandom_range(0, 7) == 0) ? 8'(255 * $urandom_range(0, 1))
                                            : 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0)
        begin
            led_top = span / (2 * g + 1);
            if (led_top > 255)
                led_top = 255;
            off_top = span / 4;
            if (off_top > 255)
                off_top = 255;
            c.led    = 8'($urandom_range(0, led_top));
            c.offset = 8'($urandom_range(0, off_top));
        end
        else
        begin
            c.led    = 8'($urandom_range(0, 255));
            c.offset = 8'($urandom_range(0, 255));
        end
        return c;
    endfunction

    task automatic queue_cmd(int unsigned led, int unsigned hue, int unsigned sat,
                             int unsigned val, int unsigned offset);
        color_cmd_t c;
        c.led    = 8'(led);
        c.hue    = 9'(hue);
        c.sat    = 8'(sat);
        c.val    = 8'(val);
        c.offset = 8'(offset);
        pending_cmds.push_back(c);
    endtask

    // Register write; leaves the caller on a falling edge
    task automatic write_reg(cfg_index_t idx, int unsigned value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= 11'(value);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_MAX_BRIGHTNESS: bright_cfg  = value & 8'hFF;
            CFG_PIN_GROUPING:   group_cfg   = value & 5'h1F;
            default:            outputs_cfg = value & 11'h7FF;
        endcase
        @(negedge clk);
    endtask

    task automatic set_config(int unsigned bright, int unsigned group, int unsigned outputs);
        write_reg(CFG_MAX_BRIGHTNESS, bright);
        write_reg(CFG_PIN_GROUPING, group);
        write_reg(CFG_NUM_OUTPUTS, outputs);
    endtask

    // Hold until the stream is empty and every channel write has come back
    task automatic drain();
        while (pending_cmds.size() != 0 || s_tvalid || expected_channels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Stimulus sequence
    initial
    begin
        int unsigned bright, group, outputs;
        @(posedge rst_n);
        @(negedge clk);

        // Reset values: zero brightness, grouping of one
        queue_cmd(0, 0, 255, 255, 0);
        queue_cmd(17, 200, 100, 180, 5);
        queue_cmd(255, 359, 0, 255, 255);
        drain();

        // Every sextant edge, hue wrap, saturation and value extremes
        set_config(255, 1, 2047);
        queue_cmd(0, 0, 255, 255, 0);
        queue_cmd(1, 59, 255, 255, 0);
        queue_cmd(2, 60, 255, 255, 1);
        queue_cmd(3, 119, 255, 255, 2);
        queue_cmd(4, 120, 255, 255, 3);
        queue_cmd(5, 179, 255, 255, 4);
        queue_cmd(6, 180, 255, 255, 5);
        queue_cmd(7, 239, 255, 255, 6);
        queue_cmd(8, 240, 255, 255, 7);
        queue_cmd(9, 299, 255, 255, 8);
        queue_cmd(10, 300, 255, 255, 9);
        queue_cmd(11, 359, 255, 255, 10);
        queue_cmd(12, 360, 200, 220, 11);
        queue_cmd(13, 511, 200, 220, 12);
        queue_cmd(14, 200, 0, 255, 13);
        queue_cmd(15, 30, 255, 0, 14);
        queue_cmd(128, 30, 128, 200, 128);
        queue_cmd(255, 100, 77, 255, 255);
        drain();

        // Wide grouping with a high LED and offset still lands inside the channel range
        write_reg(CFG_PIN_GROUPING, 16);
        queue_cmd(255, 45, 90, 200, 255);
        drain();

        // Zero grouping never gives a valid write
        write_reg(CFG_PIN_GROUPING, 0);
        queue_cmd(0, 45, 90, 200, 0);
        drain();

        // No channels present
        write_reg(CFG_PIN_GROUPING, 1);
        write_reg(CFG_NUM_OUTPUTS, 0);
        queue_cmd(0, 45, 90, 200, 0);
        drain();

        // Random phases, each under its own register setting
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == 0)
            begin
                bright = 255; group = 31; outputs = 2047;
            end
            else if (p == 1)
            begin
                bright = 0; group = 16; outputs = 1024;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       bright = 0;
                    1:       bright = 255;
                    default: bright = $urandom_range(1, 254);
                endcase
                case ($urandom_range(0, 7))
                    0:       group = 0;
                    1:       group = 31;
                    2:       group = 16;
                    3:       group = 1;
                    default: group = $urandom_range(1, 16);
                endcase
                case ($urandom_range(0, 7))
                    0:       outputs = $urandom_range(0, 7);
                    1:       outputs = 1024;
                    2:       outputs = 2047;
                    default: outputs = $urandom_range(8, 2047);
                endcase
            end
            set_config(bright, group, outputs);
            for (int i = 0; i < PHASE_ITEMS; i++)
                pending_cmds.push_back(random_color_cmd());
            drain();
        end

        if (mismatch_count == 0 && expected_channels.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Sender: present queued colors in bursts, hold each until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end
        else
        begin
            send_next = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_channels.push_back(predict_channels(cur_cmd));
                send_next = 1'b0;
            end
            if (!send_next)
            begin
                if (gap_left != 0)
                    gap_left--;
                else if (pending_cmds.size() != 0)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tdata <= {7'b0, cur_cmd.offset, cur_cmd.val, cur_cmd.sat,
                                cur_cmd.hue, cur_cmd.led};
                    send_next = 1'b1;
                    burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            s_tvalid <= send_next;
        end
    end

    // Receiver: change stall style now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (rx_left == 0)
            begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_left = $urandom_range(20, 300);
            end
            else
                rx_left--;
            rx_phase = rx_phase + 3'd1;
            case (rx_style)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                default:   m_tready <= (rx_phase < 3'd5);
            endcase
        end
    end

    // Check each channel write against the oldest prediction
    always @(posedge clk)
    begin
        channel_set_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.ok        = m_tuser[0];
            got.red_idx   = m_tdata[9:0];
            got.green_idx = m_tdata[19:10];
            got.blue_idx  = m_tdata[29:20];
            got.red_lvl   = m_tdata[37:30];
            got.green_lvl = m_tdata[45:38];
            got.blue_lvl  = m_tdata[53:46];
            if (expected_channels.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: channel write with nothing expected: %p", $realtime, got);
            end
            else
            begin
                want = expected_channels.pop_front();
                if (got.ok !== want.ok || got.red_idx !== want.red_idx ||
                    got.green_idx !== want.green_idx || got.blue_idx !== want.blue_idx ||
                    got.red_lvl !== want.red_lvl || got.green_lvl !== want.green_lvl ||
                    got.blue_lvl !== want.blue_lvl)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: channel write mismatch\n  expected %p\n  actual   %p",
                                 $realtime, want, got);
                end
            end
        end
    end

    // Watchdog: give up after a long stretch with no transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

// File: sim.f
sv/hsvrgb_pkg.sv
sv/hsvrgb_index_pipe.sv
sv/hsvrgb_color_pipe.sv
sv/hsv_to_rgb_channel_writer_top.sv
sv/hsvrgb_checker.sv
dv/testbench.sv
